// ===== src/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// hed_pkg: shared types, constants and helpers of the hash escape decoder
// Character and result types, the escape phase encoding, the result bundle
// passed from the front to the back, and hex digit helpers.
// ----------------------------------------------------------------------------
package hed_pkg;

	localparam int CHAR_W = 8;
	localparam int BND_SLOTS = 3;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
	localparam int BND_CNT_W = $clog2(BND_SLOTS + 1);

	typedef logic [CHAR_W-1:0] char_t;

	// reset value of the escape mark register
	localparam char_t ESC_RESET = 8'd35;

	// opcode of an input item
	localparam logic OPC_CHAR = 1'b0;
	localparam logic OPC_END  = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_MARK  = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// one result item
	typedef struct packed {
		char_t ch;
		logic  eoi;
	} res_t;

	// all results caused by one input item, packed from slot 0 upwards
	typedef struct packed {
		res_t [BND_SLOTS-1:0] ent;
		logic [BND_CNT_W-1:0] cnt;
	} bundle_t;

	function automatic logic is_dec(input char_t c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input char_t c);
		return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
			((c >= 8'h41) && (c <= 8'h46));
	endfunction

	// nibble value of a hex digit, letters have low nibble 1..6
	function automatic logic [3:0] hex_val(input char_t c);
		return is_dec(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
	endfunction

endpackage

// ===== src/hed_if.sv =====
// ----------------------------------------------------------------------------
// hed_in_if / hed_out_if: valid/ready channels of the hash escape decoder
// The input channel carries characters and end items, the output channel
// carries decoded characters and the end marker.
// ----------------------------------------------------------------------------
interface hed_in_if;
	logic              valid;
	logic              ready;
	logic              opcode;
	hed_pkg::char_t    in_char;

	modport source (output valid, output opcode, output in_char, input ready);
	modport sink   (input valid, input opcode, input in_char, output ready);
endinterface

interface hed_out_if;
	logic              valid;
	logic              ready;
	hed_pkg::char_t    out_char;
	logic              end_flag;

	modport source (output valid, output out_char, output end_flag, input ready);
	modport sink   (input valid, input out_char, input end_flag, output ready);
endinterface

// ===== src/hed_front.sv =====
// ----------------------------------------------------------------------------
// hed_front: accepts items and classifies them against the escape state
// Holds the escape mark register and the phase, and turns each item into a
// bundle of up to three results that is pushed to the queue.
// ----------------------------------------------------------------------------
module hed_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  hed_pkg::char_t   cfg_wdata,
	hed_in_if.sink           in_ch,
	output logic             push,
	output hed_pkg::bundle_t push_bnd,
	input  logic             q_full
);
	import hed_pkg::*;

	char_t   esc_q;
	phase_t  phase_q, phase_d;
	char_t   held_q, held_d;
	logic    acc;
	char_t   c;
	logic    ch_hex;
	logic    ch_esc;
	char_t   s_ch  [4];
	logic    s_ok  [4];
	logic    s_end [4];
	logic [BND_CNT_W-1:0] n;

	assign in_ch.ready = !q_full;
	assign acc = in_ch.valid && in_ch.ready;
	assign c = in_ch.in_char;
	assign ch_hex = is_hex(c);
	assign ch_esc = (c == esc_q);

	// escape mark register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ESC_RESET;
		end else if (cfg_we) begin
			esc_q <= cfg_wdata;
		end
	end

	// phase and held digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	// next phase
	always_comb begin
		phase_d = PH_IDLE;
		held_d  = held_q;
		if (in_ch.opcode == OPC_END) begin
			phase_d = PH_IDLE;
			held_d  = '0;
		end else begin
			unique case (phase_q)
				PH_MARK: begin
					if (ch_esc) begin
						phase_d = PH_IDLE;
					end else if (ch_hex) begin
						phase_d = PH_DIGIT;
						held_d  = c;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_DIGIT: begin
					held_d  = '0;
					phase_d = (!ch_hex && ch_esc) ? PH_MARK : PH_IDLE;
				end
				default: begin
					phase_d = ch_esc ? PH_MARK : PH_IDLE;
				end
			endcase
		end
	end

	// candidate results: held mark, held digit, character or byte, end marker
	always_comb begin
		s_ch[0] = esc_q;
		s_ch[1] = held_q;
		s_ch[2] = c;
		s_ch[3] = '0;
		for (int i = 0; i < 4; i++) begin
			s_ok[i]  = 1'b0;
			s_end[i] = 1'b0;
		end
		if (in_ch.opcode == OPC_END) begin
			unique case (phase_q)
				PH_MARK: s_ok[0] = 1'b1;
				PH_DIGIT: begin
					s_ok[0] = 1'b1;
					s_ok[1] = 1'b1;
				end
				default: ;
			endcase
			s_ok[3]  = 1'b1;
			s_end[3] = 1'b1;
		end else begin
			unique case (phase_q)
				PH_MARK: begin
					if (ch_esc) begin
						s_ok[0] = 1'b1;
					end else if (!ch_hex) begin
						s_ok[0] = 1'b1;
						s_ok[2] = 1'b1;
					end
				end
				PH_DIGIT: begin
					if (ch_hex) begin
						s_ch[2] = {hex_val(held_q), hex_val(c)};
						s_ok[2] = 1'b1;
					end else begin
						s_ok[0] = 1'b1;
						s_ok[1] = 1'b1;
						s_ok[2] = !ch_esc;
					end
				end
				default: s_ok[2] = !ch_esc;
			endcase
		end
		// zero bytes are dropped
		for (int i = 0; i < 3; i++) begin
			if (s_ch[i] == '0) begin
				s_ok[i] = 1'b0;
			end
		end
	end

	// pack the surviving results into the bundle
	always_comb begin
		push_bnd = '0;
		n = '0;
		for (int i = 0; i < 4; i++) begin
			if (s_ok[i]) begin
				push_bnd.ent[n[1:0]].ch  = s_ch[i];
				push_bnd.ent[n[1:0]].eoi = s_end[i];
				n = BND_CNT_W'(n + 1'b1);
			end
		end
		push_bnd.cnt = n;
	end

	assign push = acc && (n != '0);

endmodule

// ===== src/hed_queue.sv =====
// ----------------------------------------------------------------------------
// hed_queue: short bundle queue between front and back
// Register queue of Q_DEPTH bundles; full and empty come from the fill count.
// ----------------------------------------------------------------------------
module hed_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hed_pkg::bundle_t push_bnd,
	output logic             full,
	input  logic             pop,
	output hed_pkg::bundle_t pop_bnd,
	output logic             empty
);
	import hed_pkg::*;

	bundle_t              mem [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_bnd = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_bnd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 :
					Q_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 :
					Q_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= Q_CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= Q_CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

// ===== src/hed_back.sv =====
// ----------------------------------------------------------------------------
// hed_back: hands out the results of one bundle per output item
// Loads a bundle from the queue and presents its results in order from
// registers; the next bundle is loaded as the last result goes out.
// ----------------------------------------------------------------------------
module hed_back (
	input  logic             clk,
	input  logic             arst_n,
	input  hed_pkg::bundle_t pop_bnd,
	input  logic             q_empty,
	output logic             pop,
	hed_out_if.source        out_ch
);
	import hed_pkg::*;

	bundle_t              cur_q;
	logic [BND_CNT_W-1:0] idx_q;
	logic                 have_q;
	logic                 fire;
	logic                 done;

	assign fire = out_ch.valid && out_ch.ready;
	assign done = fire && (idx_q == BND_CNT_W'(cur_q.cnt - 1'b1));
	assign pop  = !q_empty && (!have_q || done);

	// current bundle and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			have_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			have_q <= 1'b0;
		end else if (fire) begin
			idx_q <= BND_CNT_W'(idx_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_bnd;
		end
	end

	// output item
	assign out_ch.valid    = have_q;
	assign out_ch.out_char = cur_q.ent[idx_q[1:0]].ch;
	assign out_ch.end_flag = cur_q.ent[idx_q[1:0]].eoi;

endmodule

// ===== src/hash_escape_decoder_core.sv =====
// ----------------------------------------------------------------------------
// hash_escape_decoder_core: escape decoder for names, one character per item
// Removes mark-and-hex escapes and doubled marks from a character stream,
// passes broken escapes through literally and closes each name with an end
// marker.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    opcode, in_char
//   out_ch    out  valid/ready    out_char, end_flag
//   cfg       in   cfg_we         cfg_wdata (escape mark)
//
// One input item is taken per cycle while the bundle queue has room.
// The back end emits one result per cycle while out_ch is ready, and the
// front stalls only once the two-entry queue is full. Items with no result
// never reach the back. The first result is offered once its bundle has been
// written to the queue and then loaded by the back end (queue write, then
// bundle load); arst_n clears phase, queue and output, and sets the escape
// mark to '#'.
// ----------------------------------------------------------------------------
module hash_escape_decoder_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  hed_pkg::char_t cfg_wdata,
	hed_in_if.sink         in_ch,
	hed_out_if.source      out_ch
);
	import hed_pkg::*;

	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;
	bundle_t push_bnd;
	bundle_t pop_bnd;

	// classify items against the escape state
	hed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.push      (push),
		.push_bnd  (push_bnd),
		.q_full    (q_full)
	);

	// bundle queue
	hed_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_bnd (push_bnd),
		.full     (q_full),
		.pop      (pop),
		.pop_bnd  (pop_bnd),
		.empty    (q_empty)
	);

	// result output
	hed_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop_bnd (pop_bnd),
		.q_empty (q_empty),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== src/hed_checker.sv =====
// ----------------------------------------------------------------------------
// hed_checker: port level checks of the hash escape decoder
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module hed_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input hed_pkg::char_t out_char,
	input logic           end_flag
);
	import hed_pkg::*;

	// an offered output item is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item withdrawn while stalled");

	// a stalled output item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_char) && $stable(end_flag))
		else $error("output payload changed while stalled");

	// end marker carries no character, a decoded character is never zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((end_flag && out_char == '0) || (!end_flag && out_char != '0)))
		else $error("zero byte or malformed end marker on output");

	// input is held back only while results are waiting at the output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no output pending");

endmodule

bind hash_escape_decoder_core hed_checker u_hed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.out_char),
	.end_flag  (out_ch.end_flag)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the hash escape decoder core
// Feeds names character by character with random gaps on both channels,
// first a directed table, then random names made mostly of valid, doubled
// and broken escapes under several escape marks. Every output item is
// compared against an in-bench decoder model or a typed-in expectation.
// ----------------------------------------------------------------------------
module tb;
	import hed_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_ITEMS = 17;
	localparam int N_DIRECTED = 26;
	localparam int N_MARKS = 5;

	// one row of the directed table; lit selects a typed-in expectation
	typedef struct packed {
		logic       op;
		char_t      ch;
		logic       lit;
		logic [1:0] lit_n;
		char_t      lit_a;
	} dir_row_t;

	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		{OPC_END,  8'h00, 1'b1, 2'd0, 8'h00},	// empty name, end marker only
		{OPC_CHAR, 8'hFF, 1'b1, 2'd1, 8'hFF},	// top character code
		{OPC_CHAR, 8'h00, 1'b1, 2'd0, 8'h00},	// zero character, dropped
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},	// doubled mark
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},	// mark, '4', 'f'
		{OPC_CHAR, 8'h34, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h66, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},	// mark, 'F', 'a'
		{OPC_CHAR, 8'h46, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h61, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},	// mark, '0', '0': decoded zero
		{OPC_CHAR, 8'h30, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h30, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},	// mark then non-hex 'g'
		{OPC_CHAR, 8'h67, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},	// mark, '9', new mark, end
		{OPC_CHAR, 8'h39, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},
		{OPC_END,  8'h00, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},	// mark, 'C', 'z': three items
		{OPC_CHAR, 8'h43, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h7A, 1'b0, 2'd0, 8'h00},
		{OPC_CHAR, 8'h23, 1'b0, 2'd0, 8'h00},	// end with mark and digit held
		{OPC_CHAR, 8'h62, 1'b0, 2'd0, 8'h00},
		{OPC_END,  8'hFF, 1'b0, 2'd0, 8'h00}
	};

	localparam char_t MARKS [N_MARKS] = '{8'hFF, 8'h01, 8'h41, 8'h25, 8'h23};

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_we;
	char_t cfg_wdata;

	hed_in_if  in_if ();
	hed_out_if out_if ();

	hash_escape_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	// decoder model state
	phase_t esc_phase;
	char_t  held_char;
	char_t  esc_mark;
	res_t   step_res [$];
	res_t   decoded_q [$];

	// typed-in expectation travelling with the current item
	logic       lit_on;
	logic [1:0] lit_n;
	char_t      lit_a;

	int  errors = 0;
	int  cycles = 0;
	int  sent = 0;
	bit  calm = 1'b0;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model helpers
	function automatic bit is_hex_char(input char_t c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] digit_value(input char_t c);
		if (c <= 8'h39)
			return 4'(c - 8'h30);
		else if (c >= 8'h61)
			return 4'(c - 8'h57);
		else
			return 4'(c - 8'h37);
	endfunction

	function void push_char(input char_t c);
		res_t r;
		r.ch = c;
		r.eoi = 1'b0;
		if (c != 8'h00)
			step_res.push_back(r);
	endfunction

	// character seen with no escape pending
	function void take_plain(input char_t c);
		if (c == esc_mark) begin
			esc_phase = PH_MARK;
		end else begin
			esc_phase = PH_IDLE;
			push_char(c);
		end
	endfunction

	// decode one input item into step_res
	function void decode_item(input logic op, input char_t c);
		res_t r;
		step_res.delete();
		if (op == OPC_END) begin
			case (esc_phase)
				PH_MARK: begin
					push_char(esc_mark);
				end
				PH_DIGIT: begin
					push_char(esc_mark);
					push_char(held_char);
				end
				default: ;
			endcase
			esc_phase = PH_IDLE;
			held_char = 8'h00;
			r.ch = 8'h00;
			r.eoi = 1'b1;
			step_res.push_back(r);
		end else begin
			case (esc_phase)
				PH_MARK: begin
					if (c == esc_mark) begin
						esc_phase = PH_IDLE;
						push_char(esc_mark);
					end else if (is_hex_char(c)) begin
						held_char = c;
						esc_phase = PH_DIGIT;
					end else begin
						push_char(esc_mark);
						take_plain(c);
					end
				end
				PH_DIGIT: begin
					if (is_hex_char(c)) begin
						esc_phase = PH_IDLE;
						push_char({digit_value(held_char), digit_value(c)});
					end else begin
						push_char(esc_mark);
						push_char(held_char);
						take_plain(c);
					end
					held_char = 8'h00;
				end
				default: begin
					take_plain(c);
				end
			endcase
		end
	endfunction

	task flag_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// accepted items on both channels, timeout
	always @(posedge clk) begin : watch
		res_t want;
		int   i;
		if (arst_n) begin
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycles);
				$display("** hash_escape_decoder_core: FAILED **");
				$finish;
			end else begin
				if (in_if.valid && in_if.ready) begin
					decode_item(in_if.opcode, in_if.in_char);
					if (lit_on) begin
						for (i = 0; i < lit_n; i++) begin
							want.ch = lit_a;
							want.eoi = 1'b0;
							decoded_q.push_back(want);
						end
						if (in_if.opcode == OPC_END) begin
							want.ch = 8'h00;
							want.eoi = 1'b1;
							decoded_q.push_back(want);
						end
					end else begin
						foreach (step_res[j])
							decoded_q.push_back(step_res[j]);
					end
				end
				if (out_if.valid && out_if.ready) begin
					if (decoded_q.size() == 0) begin
						flag_mismatch($sformatf("item %02h end %0b with nothing expected",
							out_if.out_char, out_if.end_flag));
					end else begin
						want = decoded_q.pop_front();
						if (out_if.out_char !== want.ch)
							flag_mismatch($sformatf("out_char %02h, expected %02h",
								out_if.out_char, want.ch));
						if (out_if.end_flag !== want.eoi)
							flag_mismatch($sformatf("end_flag %0b, expected %0b",
								out_if.end_flag, want.eoi));
					end
				end
			end
		end
	end

	// receiving side with random stalls
	initial begin : rx_side
		int stall;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				out_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_if.ready <= 1'b1;
			@(posedge clk);
			while (!out_if.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// present one item after a random gap and wait for its acceptance
	task send_item(input logic op, input char_t c, input logic lit,
			input logic [1:0] n, input char_t a);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.opcode <= op;
		in_if.in_char <= c;
		lit_on <= lit;
		lit_n <= n;
		lit_a <= lit ? a : c;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task send_char(input char_t c);
		send_item(OPC_CHAR, c, 1'b0, 2'd0, 8'h00);
	endtask

	// wait until the block is idle, then write a new escape mark
	task set_mark(input char_t m);
		in_if.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		esc_mark = m;
	endtask

	function automatic char_t pick_hex();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10)
			return char_t'(8'h30 + r);
		else if (r < 16)
			return char_t'(8'h61 + r - 10);
		else
			return char_t'(8'h41 + r - 16);
	endfunction

	// any character that neither is a hex digit nor the mark
	function automatic char_t pick_plain();
		char_t c;
		c = char_t'($urandom_range(0, 255));
		while (is_hex_char(c) || c == esc_mark)
			c = char_t'($urandom_range(0, 255));
		return c;
	endfunction

	// one random name: a few tokens, mostly escapes, then the end item
	task send_name();
		int  n_tok;
		int  kind;
		int  t;
		bit  cut;
		n_tok = $urandom_range(1, 6);
		cut = 1'b0;
		calm = ($urandom_range(0, 4) == 0);
		for (t = 0; t < n_tok && !cut; t++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: begin
					send_char(char_t'($urandom_range(0, 255)));
				end
				3, 4, 5: begin
					send_char(esc_mark);
					send_char(pick_hex());
					send_char(pick_hex());
				end
				6: begin
					send_char(esc_mark);
					send_char(esc_mark);
				end
				7: begin
					send_char(esc_mark);
					send_char(pick_plain());
				end
				8: begin
					send_char(esc_mark);
					send_char(pick_hex());
					send_char(pick_plain());
				end
				default: begin
					// escape cut short by the end item
					send_char(esc_mark);
					if ($urandom_range(0, 1))
						send_char(pick_hex());
					cut = 1'b1;
				end
			endcase
		end
		send_item(OPC_END, char_t'($urandom_range(0, 255)), 1'b0, 2'd0, 8'h00);
	endtask

	// main sequence
	initial begin : stim
		int  k;
		int  r;
		bit  paused;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		in_if.valid = 1'b0;
		in_if.opcode = OPC_CHAR;
		in_if.in_char = 8'h00;
		lit_on = 1'b0;
		lit_n = 2'd0;
		lit_a = 8'h00;
		esc_phase = PH_IDLE;
		held_char = 8'h00;
		esc_mark = ESC_RESET;
		paused = 1'b0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table under the reset mark
		for (r = 0; r < N_DIRECTED; r++)
			send_item(DIRECTED[r].op, DIRECTED[r].ch, DIRECTED[r].lit,
				DIRECTED[r].lit_n, DIRECTED[r].lit_a);

		// random names under each mark
		sent = 0;
		for (k = 0; k < N_MARKS; k++) begin
			set_mark(MARKS[k]);
			while (sent < (k + 1) * PHASE_ITEMS) begin
				send_name();
				// hold the sender until the output has drained
				if (!paused && sent >= PHASE_ITEMS / 2) begin
					in_if.valid <= 1'b0;
					while (decoded_q.size() != 0)
						@(negedge clk);
					paused = 1'b1;
				end
			end
		end
		calm = 1'b0;
		in_if.valid <= 1'b0;

		while (decoded_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (errors == 0)
			$display("** hash_escape_decoder_core: PASSED **");
		else
			$display("** hash_escape_decoder_core: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
src/hed_pkg.sv
src/hed_if.sv
src/hed_front.sv
src/hed_queue.sv
src/hed_back.sv
src/hash_escape_decoder_core.sv
src/hed_checker.sv
test/tb.sv
